@@ rtl/gcc_pkg.sv @@
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared types and constants for the graph connectivity checker.
// ----------------------------------------------------------------------------
package gcc_pkg;

  localparam int VERTEX_W   = 5;
  localparam int COUNT_W    = 6;
  localparam int OP_W       = 2;
  localparam int SET_W      = 32;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                clear;
    logic                add;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
  } adj_cmd_t;

endpackage

@@ rtl/gcc_adj_matrix.sv @@
// ----------------------------------------------------------------------------
// gcc_adj_matrix
// Adjacency bit matrix with a clear of all rows together, symmetric edge set and one
// row read port.
// ----------------------------------------------------------------------------
module gcc_adj_matrix #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  gcc_pkg::adj_cmd_t               cmd,
  input  logic [$clog2(MAX_VERTICES)-1:0] rd_idx,
  output logic [MAX_VERTICES-1:0]         rd_row
);

  localparam int IDX_W = $clog2(MAX_VERTICES);

  logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];
  logic [IDX_W-1:0]        idx_a;
  logic [IDX_W-1:0]        idx_b;

  assign idx_a  = IDX_W'(cmd.vertex_a);
  assign idx_b  = IDX_W'(cmd.vertex_b);
  assign rd_row = rows[rd_idx];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        rows[r] <= '0;
      end
    end else if (cmd.add) begin
      rows[idx_a][idx_b] <= 1'b1;
      rows[idx_b][idx_a] <= 1'b1;
    end
  end

endmodule

@@ rtl/graph_connectivity_check_top.sv @@
// ----------------------------------------------------------------------------
// graph_connectivity_check_top
// Undirected graph store with a reachability check from vertex zero.
//
// Input transactions arrive on s_tvalid/s_tready/s_tdata. Clear and add-edge
// operations are taken one per cycle and produce no output. A check makes
// the block drop s_tready while it sweeps the vertices in use, one adjacency
// row per cycle, repeating the sweep until a full pass adds no vertex; the
// single row read port sets this pace. The result register is then loaded
// from the emit state. The result (connected flag and reached set) is held
// on m_tdata with m_tvalid until m_tready is high; while it waits, later
// clear and add transactions are still taken, and a further check waits for
// the register to empty. The vertex count is to be written through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce this.
// Reset empties the graph, sets the vertex count to 32 and drops m_tvalid.
// ----------------------------------------------------------------------------
module graph_connectivity_check_top #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gcc_pkg::COUNT_W-1:0]       cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // op [1:0], vertex_a [6:2], vertex_b [11:7], zero [15:12]
  input  logic [gcc_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // connected [0], reached_set [32:1], zero [39:33]
  output logic [gcc_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int NUM_W = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W = (NUM_W > gcc_pkg::VERTEX_W) ? NUM_W : gcc_pkg::VERTEX_W;
  localparam int SAT_W = (NUM_W > gcc_pkg::COUNT_W) ? NUM_W : gcc_pkg::COUNT_W;
  localparam int EXT_W = (MAX_VERTICES > gcc_pkg::SET_W) ? MAX_VERTICES : gcc_pkg::SET_W;

  gcc_pkg::state_t                  state;
  gcc_pkg::state_t                  state_next;
  logic [gcc_pkg::COUNT_W-1:0]      vertex_count;
  logic [IDX_W-1:0]                 v;
  logic [IDX_W-1:0]                 v_next;
  logic [MAX_VERTICES-1:0]          seen;
  logic [MAX_VERTICES-1:0]          seen_next;
  logic                             changed;
  logic                             changed_next;
  logic                             out_connected;
  logic [gcc_pkg::SET_W-1:0]        out_set;
  logic                             load_out;
  logic                             grew;
  gcc_pkg::adj_cmd_t                cmd;
  logic [MAX_VERTICES-1:0]          rd_row;
  logic [MAX_VERTICES-1:0]          row;
  logic [MAX_VERTICES-1:0]          limit;
  logic [NUM_W-1:0]                 n_active;
  logic [IDX_W-1:0]                 n_last;
  logic [SAT_W-1:0]                 count_ext;
  logic [gcc_pkg::OP_W-1:0]         in_op;
  logic [gcc_pkg::VERTEX_W-1:0]     in_a;
  logic [gcc_pkg::VERTEX_W-1:0]     in_b;
  logic                             add_ok;
  logic [EXT_W-1:0]                 seen_ext;

  assign in_op = s_tdata[1:0];
  assign in_a  = s_tdata[6:2];
  assign in_b  = s_tdata[11:7];

  assign count_ext = SAT_W'(vertex_count);

  always_comb begin
    priority if (vertex_count == '0) begin
      n_active = NUM_W'(1);
    end else if (count_ext > SAT_W'(MAX_VERTICES)) begin
      n_active = NUM_W'(MAX_VERTICES);
    end else begin
      n_active = NUM_W'(count_ext);
    end
  end

  assign n_last = IDX_W'(n_active - NUM_W'(1));

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_limit
    assign limit[i] = (NUM_W'(i) < n_active);
  end

  assign add_ok = (in_a != in_b) && (CMP_W'(in_a) < CMP_W'(n_active))
                  && (CMP_W'(in_b) < CMP_W'(n_active));

  gcc_adj_matrix #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_adj (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .rd_idx (v),
    .rd_row (rd_row)
  );

  assign row = rd_row & limit;

  always_comb begin
    state_next   = state;
    v_next       = v;
    seen_next    = seen;
    changed_next = changed;
    load_out     = 1'b0;
    grew         = 1'b0;
    cmd          = '0;
    cmd.vertex_a = in_a;
    cmd.vertex_b = in_b;
    s_tready     = 1'b0;
    unique case (state)
      gcc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (in_op)
            gcc_pkg::OP_CLEAR: cmd.clear = 1'b1;
            gcc_pkg::OP_ADD:   cmd.add   = add_ok;
            gcc_pkg::OP_CHECK: begin
              state_next   = gcc_pkg::ST_WALK;
              v_next       = '0;
              seen_next    = MAX_VERTICES'(1);
              changed_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      gcc_pkg::ST_WALK: begin
        if (seen[v] && ((row & ~seen) != '0)) begin
          seen_next = seen | row;
          grew      = 1'b1;
        end
        if (v == n_last) begin
          if (changed || grew) begin
            v_next       = '0;
            changed_next = 1'b0;
          end else begin
            state_next = gcc_pkg::ST_EMIT;
          end
        end else begin
          v_next       = v + 1'b1;
          changed_next = changed | grew;
        end
      end
      gcc_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = gcc_pkg::ST_IDLE;
        end
      end
      default: state_next = gcc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gcc_pkg::ST_IDLE;
      vertex_count <= gcc_pkg::COUNT_RESET;
      v            <= '0;
      seen         <= '0;
      changed      <= 1'b0;
    end else begin
      state   <= state_next;
      v       <= v_next;
      seen    <= seen_next;
      changed <= changed_next;
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
    end
  end

  assign seen_ext = EXT_W'(seen);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_connected <= ((seen & limit) == limit);
      out_set       <= seen_ext[gcc_pkg::SET_W-1:0];
    end
  end

  assign m_tdata = {7'd0, out_set, out_connected};

endmodule

@@ tb/sv/tb_graph_connectivity_check_top.sv @@
// ----------------------------------------------------------------------------
// tb_graph_connectivity_check_top
// Self-checking testbench for the graph connectivity checker. Clear, add-edge
// and check operations are streamed in with random gaps. A local model of the
// adjacency matrix predicts each check's connected flag and reached set.
// The run steps through several vertex counts, the extremes among them, and
// includes one long output stall that makes the block stall its input.
// ----------------------------------------------------------------------------
module tb_graph_connectivity_check_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_W      = gcc_pkg::SET_W;
  localparam int OP_W       = gcc_pkg::OP_W;
  localparam int VERTEX_W   = gcc_pkg::VERTEX_W;
  localparam int COUNT_W    = gcc_pkg::COUNT_W;
  localparam int IN_DATA_W  = gcc_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = gcc_pkg::OUT_DATA_W;

  localparam int NV = SET_W;
  localparam int PHASE_ITEMS = 60;
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [VERTEX_W-1:0] va;
    logic [VERTEX_W-1:0] vb;
  } graph_op_t;

  typedef struct {
    logic            connected;
    logic [SET_W-1:0] reached;
  } reach_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [COUNT_W-1:0]    cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  graph_op_t op_q[$];
  reach_t    reach_q[$];
  logic [NV-1:0]      adj_model [NV];
  logic [COUNT_W-1:0] count_model = gcc_pkg::COUNT_RESET;
  int  ops_issued = 0;
  int  ops_taken = 0;
  int  phase_items = 0;
  int  n_errors = 0;
  bit  quiet = 1'b0;
  bit  hold_go = 1'b0;
  logic rx_hold = 1'b0;

  graph_connectivity_check_top #(
    .MAX_VERTICES(NV)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int v = 0; v < NV; v++) adj_model[v] = '0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic int active_count(logic [COUNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > NV) return NV;
    return int'(c);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic apply_graph_op(graph_op_t g);
    int n;
    logic [NV-1:0] lim;
    logic [NV-1:0] seen;
    logic [NV-1:0] prev;
    reach_t r;
    n = active_count(count_model);
    lim = '0;
    for (int v = 0; v < n; v++) lim[v] = 1'b1;
    case (g.op)
      gcc_pkg::OP_CLEAR: begin
        for (int v = 0; v < NV; v++) adj_model[v] = '0;
      end
      gcc_pkg::OP_ADD: begin
        if (g.va != g.vb && g.va < n && g.vb < n) begin
          adj_model[g.va][g.vb] = 1'b1;
          adj_model[g.vb][g.va] = 1'b1;
        end
      end
      gcc_pkg::OP_CHECK: begin
        seen = 1;
        prev = 0;
        while (seen != prev) begin
          prev = seen;
          for (int v = 0; v < n; v++) begin
            if (seen[v]) seen |= adj_model[v] & lim;
          end
        end
        r.connected = ((seen & lim) == lim);
        r.reached = seen;
        reach_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Input side.
  graph_op_t cur_op;
  int tx_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_graph_op(cur_op);
        ops_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (op_q.size() != 0) begin
          cur_op = op_q.pop_front();
          s_tdata <= IN_DATA_W'({cur_op.vb, cur_op.va, cur_op.op});
          s_tvalid <= 1'b1;
          tx_gap = quiet ? 0 : idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side.
  int rx_stall = 0;

  always @(posedge clk) begin : rx_side
    logic rdy;
    reach_t w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reach_q.size() == 0) begin
          report_mismatch($sformatf("result %h with none expected", m_tdata));
        end else begin
          w = reach_q.pop_front();
          if (m_tdata[0] !== w.connected)
            report_mismatch($sformatf("connected got %b expected %b",
                                      m_tdata[0], w.connected));
          if (m_tdata[SET_W:1] !== w.reached)
            report_mismatch($sformatf("reached_set got %h expected %h",
                                      m_tdata[SET_W:1], w.reached));
        end
      end
      rdy = 1'b1;
      if (rx_hold) begin
        rdy = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        rdy = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        rx_stall = idle_len();
        rdy = (rx_stall == 0);
      end
      m_tready <= rdy;
    end
  end

  // Long output stall while input keeps coming.
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic push_op(logic [OP_W-1:0] op, int a, int b);
    graph_op_t g;
    g.op = op;
    g.va = VERTEX_W'(a);
    g.vb = VERTEX_W'(b);
    op_q.push_back(g);
    ops_issued++;
    phase_items++;
  endtask

  task automatic push_noise();
    int v;
    v = $urandom_range(0, 31);
    case ($urandom_range(0, 2))
      0: push_op(gcc_pkg::OP_ADD, v, v);
      1: push_op(gcc_pkg::OP_ADD, v, $urandom_range(0, 31));
      default: push_op(OP_IGNORED, v, $urandom_range(0, 31));
    endcase
  endtask

  task automatic build_and_check(int n);
    int perm [NV];
    int j;
    int t;
    int mode;
    int skip;
    push_op(gcc_pkg::OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
    mode = $urandom_range(0, 3);
    if (mode <= 1) begin
      for (int i = 0; i < NV; i++) perm[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = perm[i];
        perm[i] = perm[j];
        perm[j] = t;
      end
      skip = (mode == 1 && n > 1) ? $urandom_range(1, n - 1) : 0;
      for (int i = 1; i < n; i++) begin
        j = perm[$urandom_range(0, i - 1)];
        if (i != skip) begin
          if ($urandom_range(0, 1)) push_op(gcc_pkg::OP_ADD, perm[i], j);
          else push_op(gcc_pkg::OP_ADD, j, perm[i]);
        end
        if ($urandom_range(0, 7) == 0)
          push_op(gcc_pkg::OP_CHECK, $urandom_range(0, 31), $urandom_range(0, 31));
        if ($urandom_range(0, 9) == 0) push_noise();
      end
    end else if (mode == 2) begin
      t = $urandom_range(0, 2 * n);
      repeat (t) begin
        push_op(gcc_pkg::OP_ADD, $urandom_range(0, n < NV ? n : NV - 1),
                $urandom_range(0, n < NV ? n : NV - 1));
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0: push_op(gcc_pkg::OP_ADD, $urandom_range(0, 31), $urandom_range(0, 31));
          1: push_op(gcc_pkg::OP_CHECK, $urandom_range(0, 31), $urandom_range(0, 31));
          2: push_op(gcc_pkg::OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
          default: push_noise();
        endcase
      end
    end
    push_op(gcc_pkg::OP_CHECK, $urandom_range(0, 31), $urandom_range(0, 31));
  endtask

  task automatic wait_drained();
    while (ops_taken != ops_issued || reach_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_model = c;
  endtask

  initial begin
    logic [COUNT_W-1:0] counts [10];
    counts = '{6'd32, 6'd1, 6'd0, 6'd2, 6'd63, 6'd33, 6'd17, 6'd5, 6'd0, 6'd0};
    counts[8] = COUNT_W'($urandom_range(0, 63));
    counts[9] = COUNT_W'($urandom_range(0, 63));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    push_op(gcc_pkg::OP_CHECK, 0, 0);
    push_op(gcc_pkg::OP_ADD, 0, 31);
    push_op(gcc_pkg::OP_ADD, 31, 31);
    push_op(OP_IGNORED, 31, 31);
    push_op(gcc_pkg::OP_ADD, 31, 30);
    push_op(gcc_pkg::OP_ADD, 21, 10);
    push_op(gcc_pkg::OP_ADD, 10, 21);
    push_op(gcc_pkg::OP_CHECK, 31, 31);
    push_op(gcc_pkg::OP_CLEAR, 31, 31);
    push_op(gcc_pkg::OP_CHECK, 0, 0);
    push_op(gcc_pkg::OP_ADD, 0, 1);
    push_op(gcc_pkg::OP_ADD, 1, 2);
    push_op(gcc_pkg::OP_CHECK, 0, 0);

    for (int p = 0; p < 10; p++) begin
      wait_drained();
      write_count(counts[p]);
      quiet = (p % 4 == 3);
      if (p == 0) hold_go = 1'b1;
      phase_items = 0;
      push_op(gcc_pkg::OP_CHECK, $urandom_range(0, 31), $urandom_range(0, 31));
      while (phase_items < PHASE_ITEMS) build_and_check(active_count(counts[p]));
    end

    wait_drained();
    repeat (32) @(posedge clk);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
